FILE: rtl/audio_module_command_framer_macros.svh
// assertion macros for the command framer rtl
// included by the modules that carry concurrent checks; no other dependencies
`ifndef AUDIO_MODULE_COMMAND_FRAMER_MACROS_SVH
`define AUDIO_MODULE_COMMAND_FRAMER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define ACF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acf check failed");

// next-cycle implication, disabled in reset
`define ACF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acf check failed");

`else

`define ACF_ASSERT_NOW(label, clk, rst, ante, cons)
`define ACF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/acf_pkg.sv
// shared types and constants for the command framer
// no dependencies
`default_nettype none

package acf_pkg;

  localparam int FRAME_MAX = 6;

  localparam logic [7:0] HDR_SUM    = 8'hAA;
  localparam logic [7:0] HDR_DELIM  = 8'h7E;
  localparam logic [7:0] TAIL_DELIM = 8'hEF;
  localparam logic [1:0] MAX_LEN    = 2'd2;
  localparam logic [2:0] MIN_LAST   = 3'd3;

  // frame format selected by the config register
  typedef enum logic {
    FMT_SUM   = 1'b0,
    FMT_DELIM = 1'b1
  } format_t;

  // fully built frame: bytes in transmit order and index of the final byte
  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [2:0]                last_idx;
  } frame_t;

endpackage

`default_nettype wire

FILE: rtl/acf_front.sv
// front end: config register, request accept and frame assembly
// depends on acf_pkg
`default_nettype none

module acf_front
  import acf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] command_code,
  input  logic [1:0] data_length,
  input  logic [7:0] data_first,
  input  logic [7:0] data_second,
  output logic       fr_valid,
  output frame_t     fr_frame,
  input  logic       fr_ready
);

  format_t    protocol_select;
  logic [1:0] len_sat;
  logic [7:0] checksum;
  logic [7:0] tail;
  frame_t     frame_next;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_select <= FMT_SUM;
    end else if (cfg_valid) begin
      protocol_select <= format_t'(cfg_data);
    end
  end

  // clamp length and form the additive checksum
  always_comb begin
    len_sat  = (data_length > MAX_LEN) ? MAX_LEN : data_length;
    checksum = HDR_SUM + command_code + {6'd0, len_sat}
             + ((len_sat != 2'd0) ? data_first : 8'd0)
             + ((len_sat == MAX_LEN) ? data_second : 8'd0);
  end

  // place bytes by position; the trailer fills the slots left by short data
  always_comb begin
    unique case (protocol_select)
      FMT_SUM: begin
        tail                = checksum;
        frame_next.bytes[0] = HDR_SUM;
        frame_next.bytes[1] = command_code;
        frame_next.bytes[2] = {6'd0, len_sat};
      end
      FMT_DELIM: begin
        tail                = TAIL_DELIM;
        frame_next.bytes[0] = HDR_DELIM;
        frame_next.bytes[1] = {6'd0, len_sat} + 8'd2;
        frame_next.bytes[2] = command_code;
      end
      default: begin
        tail                = checksum;
        frame_next.bytes[0] = HDR_SUM;
        frame_next.bytes[1] = command_code;
        frame_next.bytes[2] = {6'd0, len_sat};
      end
    endcase
    frame_next.bytes[3] = (len_sat != 2'd0) ? data_first : tail;
    frame_next.bytes[4] = (len_sat == MAX_LEN) ? data_second : tail;
    frame_next.bytes[5] = tail;
    frame_next.last_idx = MIN_LAST + {1'b0, len_sat};
  end

  // one-deep hold stage; refills in the cycle it drains
  assign in_ready = !fr_valid || fr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ready) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/acf_queue.sv
// short frame queue between the front end and the serializer
// depends on acf_pkg and the assertion macro header
`default_nettype none
`include "audio_module_command_framer_macros.svh"

module acf_queue
  import acf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   push_ready,
  input  frame_t push_frame,
  output logic   head_valid,
  output frame_t head_frame,
  input  logic   pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head_frame = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ACF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL)
  `ACF_ASSERT_NEXT(a_push_counts, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `ACF_ASSERT_NOW(a_ptr_gap, clk, rst, count == '0, wr_ptr == rd_ptr)

endmodule

`default_nettype wire

FILE: rtl/acf_back.sv
// serializer: walks the head frame one byte per beat into the output register
// depends on acf_pkg and the assertion macro header
`default_nettype none
`include "audio_module_command_framer_macros.svh"

module acf_back
  import acf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  frame_t     head_frame,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last
);

  logic [2:0] idx;
  logic       load;
  logic       last_sel;

  // output slot free or draining this cycle
  assign load     = head_valid && (!out_valid || out_ready);
  assign last_sel = (idx == head_frame.last_idx);
  assign pop      = load && last_sel;

  // byte index within the head frame
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last_sel ? 3'd0 : idx + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= head_frame.bytes[idx];
      frame_last <= last_sel;
    end
  end

  `ACF_ASSERT_NEXT(a_idx_wrap, clk, rst, load && last_sel, idx == 3'd0)
  `ACF_ASSERT_NOW(a_idx_in_frame, clk, rst, head_valid, idx <= head_frame.last_idx)
  `ACF_ASSERT_NOW(a_idx_idle, clk, rst, !head_valid, idx == 3'd0)

endmodule

`default_nettype wire

FILE: rtl/audio_module_command_framer.sv
// top level of the command framer: front end, frame queue, serializer
// depends on acf_pkg, acf_front, acf_queue, acf_back
//
// channel   dir  handshake            payload
// cfg       in   cfg_valid/cfg_ready  cfg_data (frame format)
// in        in   in_valid/in_ready    command_code, data_length, data_first, data_second
// out       out  out_valid/out_ready  frame_byte, frame_last
//
// a request becomes a frame of 4 to 6 bytes, sent one byte per beat; the
// serializer's output register sends one byte per cycle while out_ready is high,
// and new requests are taken while an earlier frame is sent, if the queue has room
// a request passes the front end's hold register, the queue and the output register
// rst is synchronous; it clears the format to the checksummed one and empties
// all stages; output stalls back up through the queue to in_ready
`default_nettype none

module audio_module_command_framer
  import acf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] command_code,
  input  logic [1:0] data_length,
  input  logic [7:0] data_first,
  input  logic [7:0] data_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last
);

  logic   fr_valid;
  logic   fr_ready;
  frame_t fr_frame;
  logic   head_valid;
  frame_t head_frame;
  logic   pop;

  // accept and build frames
  acf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command_code (command_code),
    .data_length  (data_length),
    .data_first   (data_first),
    .data_second  (data_second),
    .fr_valid     (fr_valid),
    .fr_frame     (fr_frame),
    .fr_ready     (fr_ready)
  );

  // decoupling queue
  acf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_ready (fr_ready),
    .push_frame (fr_frame),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop)
  );

  // byte serializer
  acf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
  );

endmodule

`default_nettype wire

FILE: tb/tb_audio_module_command_framer.sv
// self-checking testbench for the audio module command framer
// depends on acf_pkg and audio_module_command_framer; drives both frame formats
`timescale 1ns / 100ps

// one expected beat of the serial frame
typedef struct packed {
  logic [7:0] value;
  logic       last;
} frame_beat_t;

// expected frame bytes, built when a request is accepted, checked in order
class frame_tracker;
  frame_beat_t     frame_bytes_due[$];
  acf_pkg::format_t fmt;
  int unsigned     errors;
  int unsigned     beats_checked;

  function new();
    fmt = acf_pkg::FMT_SUM;
    errors = 0;
    beats_checked = 0;
  endfunction

  function int unsigned pending();
    return frame_bytes_due.size();
  endfunction

  function void report(string what, logic [7:0] want_b, logic want_l,
                       logic [7:0] got_b, logic got_l);
    errors++;
    if (errors <= 10)
      $display("mismatch: %s  expected byte %02h last %0b  got byte %02h last %0b",
               what, want_b, want_l, got_b, got_l);
  endfunction

  // build the whole frame for an accepted request
  function void add_request(logic [7:0] cmd, logic [1:0] len_in,
                            logic [7:0] d0, logic [7:0] d1);
    logic [7:0]  frame [$];
    logic [1:0]  len;
    logic [7:0]  sum;
    frame_beat_t beat;
    // a length of three is clipped to two
    len = (len_in > acf_pkg::MAX_LEN) ? acf_pkg::MAX_LEN : len_in;
    if (fmt == acf_pkg::FMT_DELIM) begin
      frame.push_back(acf_pkg::HDR_DELIM);
      frame.push_back({6'd0, len} + 8'd2);
      frame.push_back(cmd);
      if (len >= 2'd1) frame.push_back(d0);
      if (len == 2'd2) frame.push_back(d1);
      frame.push_back(acf_pkg::TAIL_DELIM);
    end else begin
      sum = acf_pkg::HDR_SUM + cmd + {6'd0, len};
      frame.push_back(acf_pkg::HDR_SUM);
      frame.push_back(cmd);
      frame.push_back({6'd0, len});
      if (len >= 2'd1) begin
        frame.push_back(d0);
        sum = sum + d0;
      end
      if (len == 2'd2) begin
        frame.push_back(d1);
        sum = sum + d1;
      end
      frame.push_back(sum);
    end
    foreach (frame[i]) begin
      beat.value = frame[i];
      beat.last  = (i == frame.size() - 1);
      frame_bytes_due.push_back(beat);
    end
  endfunction

  // compare one output beat with the oldest expected byte
  function void check_beat(logic [7:0] got_b, logic got_l);
    frame_beat_t want;
    beats_checked++;
    if (frame_bytes_due.size() == 0) begin
      report("beat with nothing expected", 8'h00, 1'b0, got_b, got_l);
      return;
    end
    want = frame_bytes_due.pop_front();
    if (got_b !== want.value || got_l !== want.last)
      report("frame beat", want.value, want.last, got_b, got_l);
  endfunction

  // anything still expected at the end is a failure
  function void close_out();
    frame_beat_t want;
    while (frame_bytes_due.size() != 0) begin
      want = frame_bytes_due.pop_front();
      report("beat never sent", want.value, want.last, 8'h00, 1'b0);
    end
  endfunction
endclass

module tb_audio_module_command_framer;
  import acf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 31;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] command_code = 8'h00;
  logic [1:0] data_length = 2'd0;
  logic [7:0] data_first = 8'h00;
  logic [7:0] data_second = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_last;

  frame_tracker tracker = new();

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned long_holds = 0;
  int unsigned format_writes = 0;

  audio_module_command_framer u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command_code (command_code),
    .data_length  (data_length),
    .data_first   (data_first),
    .data_second  (data_second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .frame_last   (frame_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("audio_module_command_framer regression: fail");
      $finish;
    end
  end

  // receiver: random stalls per beat when rx_idle_on is set, plus a long hold-off when rx_hold is set
  initial begin : receiver
    int unsigned gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        long_holds++;
      end
      gap = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_beat(frame_byte, frame_last);
    end
  end

  // offer one request beat and note it once accepted
  task automatic send_request(logic [7:0] cmd, logic [1:0] len,
                              logic [7:0] d0, logic [7:0] d1);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command_code <= cmd;
    data_length  <= len;
    data_first   <= d0;
    data_second  <= d1;
    @(posedge clk);
    while (!in_ready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    tracker.add_request(cmd, len, d0, d1);
    requests_sent++;
  endtask

  task automatic send_random_request();
    send_request(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // drop valid and wait for every expected byte
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // format change, only with the block idle
  task automatic set_format(format_t f);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.fmt = f;
    format_writes++;
  endtask

  // boundary values, clipped length, ignored data bytes, checksum wrap
  task automatic send_directed_set();
    send_request(8'h00, 2'd0, 8'h00, 8'h00);
    send_request(8'hFF, 2'd0, 8'hA5, 8'h5A);
    send_request(8'hFF, 2'd1, 8'hFF, 8'h00);
    send_request(8'h00, 2'd1, 8'h00, 8'hFF);
    send_request(8'h55, 2'd2, 8'h00, 8'hFF);
    send_request(8'hFF, 2'd2, 8'hFF, 8'hFF);
    send_request(8'hAA, 2'd2, 8'h80, 8'h01);
    send_request(8'h01, 2'd3, 8'h12, 8'h34);
    send_request(8'hFF, 2'd3, 8'hFF, 8'hFF);
    send_request(8'h7E, 2'd1, 8'hEF, 8'h00);
    send_request(8'h56, 2'd2, 8'hAA, 8'h55);
    send_request(8'h80, 2'd0, 8'h00, 8'h00);
  endtask

  // main sequence
  initial begin : stimulus
    format_t phase_fmt [RAND_PHASES];
    phase_fmt = '{FMT_SUM, FMT_DELIM, FMT_DELIM, FMT_SUM, FMT_DELIM, FMT_SUM};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part in both formats
    set_format(FMT_SUM);
    send_directed_set();
    set_format(FMT_DELIM);
    send_directed_set();

    // random phases with different idling and pressure
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (phase_fmt[p] != tracker.fmt) set_format(phase_fmt[p]);
      else drain();
      case (p)
        1: begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        2: begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b1;
          rx_hold    = 200;
        end
        3: begin
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b0;
        end
        4: begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b1;
        end
        default: begin
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b1;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    end

    // wind down
    drain();
    repeat (20) @(posedge clk);
    tracker.close_out();

    $display("covered %0d requests, %0d frame beats, %0d format writes in both formats",
             requests_sent, tracker.beats_checked, format_writes);
    $display("input held off for %0d cycles, %0d long output hold-offs, %0d errors",
             input_stall_cycles, long_holds, tracker.errors);
    if (tracker.errors == 0) begin
      $display("audio_module_command_framer regression: pass");
    end else begin
      $display("audio_module_command_framer regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/acf_pkg.sv
rtl/acf_front.sv
rtl/acf_queue.sv
rtl/acf_back.sv
rtl/audio_module_command_framer.sv
tb/tb_audio_module_command_framer.sv
